// ===== sv/hrt_pkg.sv =====
package hrt_pkg;

  localparam int MAX_HEADER_LIMIT_DEF = 64;
  localparam logic [6:0] HEADER_LIMIT_RST = 7'd12;

  // result queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_SLOTS = 3;

  localparam logic [1:0] REG_HEADER_LIMIT = 2'd0;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_KEY     = 3'd3,
    PH_VALUE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    PK_NONE  = 3'd0,
    PK_CR    = 3'd1,
    PK_COLON = 3'd2,
    PK_PCT   = 3'd3,
    PK_PCT1  = 3'd4
  } pend_t;

  typedef enum logic [2:0] {
    EV_DATA = 3'd0,
    EV_END  = 3'd1,
    EV_DONE = 3'd2,
    EV_BAD  = 3'd3,
    EV_OVF  = 3'd4
  } event_t;

  localparam logic [2:0] TK_METHOD  = 3'd0;
  localparam logic [2:0] TK_URL     = 3'd1;
  localparam logic [2:0] TK_VERSION = 3'd2;
  localparam logic [2:0] TK_KEY     = 3'd3;
  localparam logic [2:0] TK_VALUE   = 3'd4;

  typedef struct packed {
    event_t     ev;
    logic [2:0] tok;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]             n;
    res_t [Q_SLOTS-1:0]     r;
  } push_t;

  function automatic res_t mk(event_t ev, logic [2:0] tok, logic [7:0] b);
    res_t x;
    x.ev   = ev;
    x.tok  = tok;
    x.data = (ev == EV_DATA) ? b : 8'h00;
    x.last = 1'b0;
    return x;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

endpackage

// ===== sv/hrt_front.sv =====
module hrt_front #(
  parameter int MAX_HEADER_LIMIT = hrt_pkg::MAX_HEADER_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic [6:0]    header_limit,
  input  logic          space_ok,
  output hrt_pkg::push_t push
);

  localparam int LimCap = (MAX_HEADER_LIMIT < 127) ? MAX_HEADER_LIMIT : 127;
  localparam logic [6:0] LIM_CAP = 7'(LimCap);

  hrt_pkg::phase_t phase, phase_next;
  hrt_pkg::pend_t  pend, pend_next;
  logic [7:0]      pending_hex, pending_hex_next;
  logic [6:0]      header_count, header_count_next;

  logic                          accept;
  logic [6:0]                    lim;
  logic [2:0]                    cur_tok;
  logic [1:0]                    n;
  logic                          use_plain;
  hrt_pkg::res_t [hrt_pkg::Q_SLOTS-1:0] r;

  assign s_tready = space_ok;
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    lim = header_limit;
    if (lim == 7'd0) lim = 7'd1;
    if (lim > LIM_CAP) lim = LIM_CAP;
  end

  assign cur_tok = (phase > hrt_pkg::PH_VALUE) ? hrt_pkg::TK_VALUE : 3'(phase);

  always_comb begin
    phase_next        = phase;
    pend_next         = hrt_pkg::PK_NONE;
    pending_hex_next  = pending_hex;
    header_count_next = header_count;
    n                 = 2'd0;
    use_plain         = 1'b0;
    r                 = '0;

    case (pend)
      hrt_pkg::PK_CR: begin
        if (s_tdata == hrt_pkg::CH_LF) begin
          case (phase)
            hrt_pkg::PH_METHOD, hrt_pkg::PH_URL: begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_BAD, cur_tok, 8'h00);
              n = n + 2'd1;
              phase_next = hrt_pkg::PH_METHOD;
              header_count_next = 7'd0;
            end
            hrt_pkg::PH_VERSION: begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_END, hrt_pkg::TK_VERSION, 8'h00);
              n = n + 2'd1;
              phase_next = hrt_pkg::PH_KEY;
            end
            hrt_pkg::PH_KEY: begin
              // blank line: request complete
              r[n] = hrt_pkg::mk(hrt_pkg::EV_DONE, hrt_pkg::TK_KEY, 8'h00);
              n = n + 2'd1;
              phase_next = hrt_pkg::PH_METHOD;
              header_count_next = 7'd0;
            end
            default: begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_END, hrt_pkg::TK_VALUE, 8'h00);
              n = n + 2'd1;
              if (header_count < lim) begin
                header_count_next = header_count + 7'd1;
              end else begin
                r[n] = hrt_pkg::mk(hrt_pkg::EV_OVF, hrt_pkg::TK_VALUE, 8'h00);
                n = n + 2'd1;
              end
              phase_next = hrt_pkg::PH_KEY;
            end
          endcase
        end else begin
          // lone CR is data
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, cur_tok, hrt_pkg::CH_CR);
          n = n + 2'd1;
          use_plain = 1'b1;
        end
      end
      hrt_pkg::PK_COLON: begin
        if (s_tdata == hrt_pkg::CH_SP) begin
          r[n] = hrt_pkg::mk(hrt_pkg::EV_END, hrt_pkg::TK_KEY, 8'h00);
          n = n + 2'd1;
          phase_next = hrt_pkg::PH_VALUE;
        end else begin
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_KEY, hrt_pkg::CH_COLON);
          n = n + 2'd1;
          use_plain = 1'b1;
        end
      end
      hrt_pkg::PK_PCT: begin
        if (hrt_pkg::is_hex(s_tdata)) begin
          pending_hex_next = s_tdata;
          pend_next = hrt_pkg::PK_PCT1;
        end else begin
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, hrt_pkg::CH_PCT);
          n = n + 2'd1;
          use_plain = 1'b1;
        end
      end
      hrt_pkg::PK_PCT1: begin
        if (hrt_pkg::is_hex(s_tdata)) begin
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_URL,
                             {hrt_pkg::hex_val(pending_hex), hrt_pkg::hex_val(s_tdata)});
          n = n + 2'd1;
        end else begin
          // bad escape: pass both held bytes through
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, hrt_pkg::CH_PCT);
          n = n + 2'd1;
          r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, pending_hex);
          n = n + 2'd1;
          use_plain = 1'b1;
        end
        pending_hex_next = 8'h00;
      end
      default: begin
        use_plain = 1'b1;
      end
    endcase

    if (use_plain) begin
      if (s_tdata == hrt_pkg::CH_CR) begin
        pend_next = hrt_pkg::PK_CR;
      end else begin
        case (phase)
          hrt_pkg::PH_METHOD: begin
            if (s_tdata == hrt_pkg::CH_SP) begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_END, hrt_pkg::TK_METHOD, 8'h00);
              phase_next = hrt_pkg::PH_URL;
            end else begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_METHOD, s_tdata);
            end
            n = n + 2'd1;
          end
          hrt_pkg::PH_URL: begin
            if (s_tdata == hrt_pkg::CH_SP) begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_END, hrt_pkg::TK_URL, 8'h00);
              n = n + 2'd1;
              phase_next = hrt_pkg::PH_VERSION;
            end else if (s_tdata == hrt_pkg::CH_PCT) begin
              pend_next = hrt_pkg::PK_PCT;
            end else begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, s_tdata);
              n = n + 2'd1;
            end
          end
          hrt_pkg::PH_VERSION: begin
            r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_VERSION, s_tdata);
            n = n + 2'd1;
          end
          hrt_pkg::PH_KEY: begin
            if (s_tdata == hrt_pkg::CH_COLON) begin
              pend_next = hrt_pkg::PK_COLON;
            end else begin
              r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_KEY, s_tdata);
              n = n + 2'd1;
            end
          end
          default: begin
            r[n] = hrt_pkg::mk(hrt_pkg::EV_DATA, hrt_pkg::TK_VALUE, s_tdata);
            n = n + 2'd1;
          end
        endcase
      end
    end

    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
  end

  assign push.n = accept ? n : 2'd0;
  assign push.r = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hrt_pkg::PH_METHOD;
      pend         <= hrt_pkg::PK_NONE;
      pending_hex  <= 8'h00;
      header_count <= 7'd0;
    end else if (accept) begin
      phase        <= phase_next;
      pend         <= pend_next;
      pending_hex  <= pending_hex_next;
      header_count <= header_count_next;
    end
  end

endmodule

// ===== sv/hrt_queue.sv =====
module hrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  hrt_pkg::push_t push,
  output logic           space_ok,
  output logic           m_tvalid,
  input  logic           m_tready,
  output hrt_pkg::res_t  head
);

  localparam int PW = $clog2(hrt_pkg::Q_DEPTH);
  localparam int CW = $clog2(hrt_pkg::Q_DEPTH + 1);
  localparam logic [CW-1:0] SPACE_MAX = CW'(hrt_pkg::Q_DEPTH - hrt_pkg::Q_SLOTS);

  hrt_pkg::res_t mem [hrt_pkg::Q_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count, count_next;
  logic          pop;

  assign m_tvalid = (count != '0);
  assign head     = mem[rp];
  assign pop      = m_tvalid & m_tready;
  // room for the worst-case burst of one input word
  assign space_ok = (count <= SPACE_MAX);

  assign count_next = count + CW'(push.n) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < hrt_pkg::Q_SLOTS; i++) begin
      if (2'(i) < push.n) mem[wp + PW'(i)] <= push.r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push.n);
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

endmodule

// ===== sv/http_request_tokenizer.sv =====
// HTTP/1.1 request header tokenizer.
// Slave stream: one raw request byte per word in s_tdata[7:0].
// Master stream: one token event per word; m_tdata carries the data byte,
// m_tuser the event code and token id, m_tlast marks the final event that
// one input byte caused. An input byte gives zero to three events.
// The front stage classifies a byte in the cycle it is accepted and writes
// its events into an 8-entry result queue; the back drains one event per
// cycle while m_tready is high. Queue memory and count are registered.
// Throughput: one byte per cycle while the queue holds at most five
// events; bytes that expand to two or three events are absorbed by the
// queue, and the sustained output rate is one event per cycle while
// m_tready is high. A stalled receiver fills the queue; s_tready drops
// once fewer than three entries are free, so no event is ever dropped.
// Reset (rst, synchronous) empties the queue, returns the parser to the
// method field of the request line and sets header_limit to 12, at APB
// byte address 0. The user must write it only while idle (no check).
module http_request_tokenizer #(
  parameter int MAX_HEADER_LIMIT = hrt_pkg::MAX_HEADER_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data_byte
  output logic [5:0]  m_tuser,   // [2:0] event_res, [5:3] token
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]     header_limit;
  logic           space_ok;
  hrt_pkg::push_t push;
  hrt_pkg::res_t  head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= hrt_pkg::HEADER_LIMIT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == hrt_pkg::REG_HEADER_LIMIT) begin
      header_limit <= pwdata[6:0];
    end
  end

  assign prdata = (paddr == hrt_pkg::REG_HEADER_LIMIT) ? {25'd0, header_limit} : 32'd0;

  hrt_front #(
    .MAX_HEADER_LIMIT(MAX_HEADER_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .header_limit (header_limit),
    .space_ok     (space_ok),
    .push         (push)
  );

  hrt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = head.data;
  assign m_tuser = {head.tok, head.ev};
  assign m_tlast = head.last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] LIMIT_ADDR = 2'(4 * hrt_pkg::REG_HEADER_LIMIT);
  localparam int PREDICT = -1;
  localparam hrt_pkg::res_t NO_EV = '0;
  localparam int PHASE_BYTES = 40;

  typedef struct packed {
    logic [7:0]            b;
    logic                  by_hand;
    logic [1:0]            n;
    hrt_pkg::res_t [2:0]   ev;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_CADENCE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] data_byte
  logic [5:0]  m_tuser;           // [2:0] event_res, [5:3] token
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  http_request_tokenizer uut (.*);

  always #4 clk = ~clk;

  // tokenizer state as the predictor sees it
  hrt_pkg::phase_t tok_phase;
  hrt_pkg::pend_t  held_kind;
  logic [7:0]      held_hex;
  logic [6:0]      hdr_count;
  logic [6:0]      hdr_limit;
  hrt_pkg::res_t   step_buf [0:2];
  int              step_n;

  hrt_pkg::res_t expected_events [$];
  dir_row_t      sent_rows [$];
  dir_row_t      dir_rows [$];
  logic [7:0]    req_bytes [$];
  logic [6:0]    limit_plan [0:4] = '{7'd0, 7'd2, 7'd127, 7'd3, 7'd64};

  int mismatches = 0;
  int words_checked = 0;
  int bytes_in = 0;
  int settings_used = 0;
  int burst_left = 0;
  int event_tally [0:7];

  function automatic hrt_pkg::res_t res_of(hrt_pkg::event_t ev, logic [2:0] tok,
                                           logic [7:0] b, logic l);
    hrt_pkg::res_t x;
    x.ev   = ev;
    x.tok  = tok;
    x.data = (ev == hrt_pkg::EV_DATA) ? b : 8'h00;
    x.last = l;
    return x;
  endfunction

  function automatic void emit(hrt_pkg::event_t ev, logic [2:0] tok, logic [7:0] b);
    step_buf[step_n] = res_of(ev, tok, b, 1'b0);
    step_n++;
  endfunction

  // bit 4 set when c is a hex digit, low nibble its value
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (b == hrt_pkg::CH_CR) begin
      held_kind = hrt_pkg::PK_CR;
      return;
    end
    case (tok_phase)
      hrt_pkg::PH_METHOD: begin
        if (b == hrt_pkg::CH_SP) begin
          emit(hrt_pkg::EV_END, hrt_pkg::TK_METHOD, 8'h00);
          tok_phase = hrt_pkg::PH_URL;
        end else emit(hrt_pkg::EV_DATA, hrt_pkg::TK_METHOD, b);
      end
      hrt_pkg::PH_URL: begin
        if (b == hrt_pkg::CH_SP) begin
          emit(hrt_pkg::EV_END, hrt_pkg::TK_URL, 8'h00);
          tok_phase = hrt_pkg::PH_VERSION;
        end else if (b == hrt_pkg::CH_PCT) held_kind = hrt_pkg::PK_PCT;
        else emit(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, b);
      end
      hrt_pkg::PH_VERSION: emit(hrt_pkg::EV_DATA, hrt_pkg::TK_VERSION, b);
      hrt_pkg::PH_KEY: begin
        if (b == hrt_pkg::CH_COLON) held_kind = hrt_pkg::PK_COLON;
        else emit(hrt_pkg::EV_DATA, hrt_pkg::TK_KEY, b);
      end
      default: emit(hrt_pkg::EV_DATA, hrt_pkg::TK_VALUE, b);
    endcase
  endfunction

  function automatic void finish_line();
    logic [6:0] cap;
    cap = hdr_limit;
    if (cap == 7'd0) cap = 7'd1;
    if (cap > 7'(hrt_pkg::MAX_HEADER_LIMIT_DEF)) cap = 7'(hrt_pkg::MAX_HEADER_LIMIT_DEF);
    case (tok_phase)
      hrt_pkg::PH_METHOD, hrt_pkg::PH_URL: begin
        emit(hrt_pkg::EV_BAD, tok_phase, 8'h00);
        tok_phase = hrt_pkg::PH_METHOD;
        hdr_count = 7'd0;
      end
      hrt_pkg::PH_VERSION: begin
        emit(hrt_pkg::EV_END, hrt_pkg::TK_VERSION, 8'h00);
        tok_phase = hrt_pkg::PH_KEY;
      end
      hrt_pkg::PH_KEY: begin
        emit(hrt_pkg::EV_DONE, hrt_pkg::TK_KEY, 8'h00);
        tok_phase = hrt_pkg::PH_METHOD;
        hdr_count = 7'd0;
      end
      default: begin
        emit(hrt_pkg::EV_END, hrt_pkg::TK_VALUE, 8'h00);
        if (hdr_count < cap) hdr_count++;
        else emit(hrt_pkg::EV_OVF, hrt_pkg::TK_VALUE, 8'h00);
        tok_phase = hrt_pkg::PH_KEY;
      end
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    hrt_pkg::pend_t pk;
    logic [4:0]     lo;
    logic [4:0]     hi;
    pk = held_kind;
    held_kind = hrt_pkg::PK_NONE;
    step_n = 0;
    lo = nibble_of(b);
    case (pk)
      hrt_pkg::PK_CR: begin
        if (b == hrt_pkg::CH_LF) finish_line();
        else begin
          emit(hrt_pkg::EV_DATA, tok_phase, hrt_pkg::CH_CR);
          take_plain(b);
        end
      end
      hrt_pkg::PK_COLON: begin
        if (b == hrt_pkg::CH_SP) begin
          emit(hrt_pkg::EV_END, hrt_pkg::TK_KEY, 8'h00);
          tok_phase = hrt_pkg::PH_VALUE;
        end else begin
          emit(hrt_pkg::EV_DATA, hrt_pkg::TK_KEY, hrt_pkg::CH_COLON);
          take_plain(b);
        end
      end
      hrt_pkg::PK_PCT: begin
        if (lo[4]) begin
          held_hex = b;
          held_kind = hrt_pkg::PK_PCT1;
        end else begin
          emit(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, hrt_pkg::CH_PCT);
          take_plain(b);
        end
      end
      hrt_pkg::PK_PCT1: begin
        hi = nibble_of(held_hex);
        if (lo[4]) emit(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, {hi[3:0], lo[3:0]});
        else begin
          emit(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, hrt_pkg::CH_PCT);
          emit(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, held_hex);
          take_plain(b);
        end
        held_hex = 8'h00;
      end
      default: take_plain(b);
    endcase
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void add_row(logic [7:0] b, int n, hrt_pkg::res_t e0,
                                  hrt_pkg::res_t e1, hrt_pkg::res_t e2);
    dir_row_t r;
    r.b = b;
    r.by_hand = (n >= 0);
    r.n = 2'((n < 0) ? 0 : n);
    r.ev[0] = e0;
    r.ev[1] = e1;
    r.ev[2] = e2;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("a" + k - 10);
    return 8'("A" + k - 16);
  endfunction

  // checks leaving words, and predicts every accepted byte
  always @(posedge clk) begin : watch
    hrt_pkg::res_t got;
    hrt_pkg::res_t want;
    dir_row_t      row;
    if (rst) begin
      tok_phase = hrt_pkg::PH_METHOD;
      held_kind = hrt_pkg::PK_NONE;
      held_hex  = 8'h00;
      hdr_count = 7'd0;
      hdr_limit = hrt_pkg::HEADER_LIMIT_RST;
    end else begin
      if (m_tvalid && m_tready) begin
        got.ev   = hrt_pkg::event_t'(m_tuser[2:0]);
        got.tok  = m_tuser[5:3];
        got.data = m_tdata;
        got.last = m_tlast;
        if (expected_events.size() == 0) begin
          flag_error($sformatf("unexpected word: ev=%0d tok=%0d data=%02h last=%0b",
                               got.ev, got.tok, got.data, got.last));
        end else begin
          want = expected_events.pop_front();
          words_checked++;
          event_tally[want.ev]++;
          if (got.ev !== want.ev || got.tok !== want.tok ||
              got.data !== want.data || got.last !== want.last)
            flag_error($sformatf(
              "word %0d: expected ev=%0d tok=%0d data=%02h last=%0b, got ev=%0d tok=%0d data=%02h last=%0b",
              words_checked, want.ev, want.tok, want.data, want.last,
              got.ev, got.tok, got.data, got.last));
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_in++;
        row = '0;
        if (sent_rows.size() != 0) row = sent_rows.pop_front();
        tokenize_byte(s_tdata);
        if (row.by_hand) begin
          for (int i = 0; i < row.n; i++) expected_events.push_back(row.ev[i]);
        end else begin
          for (int i = 0; i < step_n; i++) expected_events.push_back(step_buf[i]);
        end
      end
    end
  end

  // receiver: changes its stall habit every so often
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_hold = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 150);
    end else rx_left <= rx_left - 1;
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      RX_HOLD: begin
        if (rx_hold > 0) begin
          m_tready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_hold <= $urandom_range(4, 20);
        end
      end
      default: m_tready <= (rx_left[1:0] != 2'd0);
    endcase
  end

  task automatic send_byte(input dir_row_t row);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 3);
        8:          gap = $urandom_range(4, 12);
        default:    gap = $urandom_range(20, 40);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    sent_rows.push_back(row);
    s_tvalid <= 1'b1;
    s_tdata  <= row.b;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the sender until every expected word is out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_header_limit(input logic [6:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {25'd0, v}, rd);
    hdr_limit = v;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {25'd0, v})
      flag_error($sformatf("header_limit readback: expected %0d, got %0h", v, rd));
    settings_used++;
  endtask

  // one request into req_bytes: mostly well formed, some broken, some noise
  task automatic build_request();
    int         shape;
    int         n;
    int         k;
    logic [7:0] c;
    req_bytes.delete();
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      n = $urandom_range(3, 12);
      repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
      // blank lines pull the parser back to the request line
      req_bytes.push_back(hrt_pkg::CH_CR);
      req_bytes.push_back(hrt_pkg::CH_LF);
      req_bytes.push_back(hrt_pkg::CH_CR);
      req_bytes.push_back(hrt_pkg::CH_LF);
      return;
    end
    n = $urandom_range(1, 6);
    repeat (n) req_bytes.push_back(8'($urandom_range("A", "Z")));
    if (shape != 7) req_bytes.push_back(hrt_pkg::CH_SP);
    req_bytes.push_back("/");
    n = $urandom_range(0, 6);
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        c = 8'($urandom_range(8'h21, 8'h7e));
        req_bytes.push_back((c == hrt_pkg::CH_PCT) ? 8'h5f : c);
      end else if (k < 9) begin
        req_bytes.push_back(hrt_pkg::CH_PCT);
        req_bytes.push_back(hex_char());
        req_bytes.push_back(hex_char());
      end else begin
        req_bytes.push_back(hrt_pkg::CH_PCT);
        if ($urandom_range(0, 1) == 1) req_bytes.push_back(hex_char());
        req_bytes.push_back(8'($urandom_range("g", "z")));
      end
    end
    if (shape != 8) req_bytes.push_back(hrt_pkg::CH_SP);
    n = $urandom_range(1, 4);
    repeat (n) req_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
    req_bytes.push_back(hrt_pkg::CH_CR);
    req_bytes.push_back(hrt_pkg::CH_LF);
    n = $urandom_range(0, 4);
    repeat (n) begin
      k = $urandom_range(1, 4);
      repeat (k) begin
        if ($urandom_range(0, 7) == 0) req_bytes.push_back(hrt_pkg::CH_COLON);
        else req_bytes.push_back(8'($urandom_range("a", "z")));
      end
      req_bytes.push_back(hrt_pkg::CH_COLON);
      req_bytes.push_back(hrt_pkg::CH_SP);
      k = $urandom_range(0, 5);
      repeat (k) begin
        case ($urandom_range(0, 9))
          0: begin
            req_bytes.push_back(hrt_pkg::CH_CR);
            req_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
          end
          1: req_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
          default: req_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        endcase
      end
      req_bytes.push_back(hrt_pkg::CH_CR);
      req_bytes.push_back(hrt_pkg::CH_LF);
    end
    req_bytes.push_back(hrt_pkg::CH_CR);
    req_bytes.push_back(hrt_pkg::CH_LF);
    if (shape == 6)
      req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    dir_row_t    row;
    int          phase_bytes;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {25'd0, hrt_pkg::HEADER_LIMIT_RST})
      flag_error($sformatf("header_limit after reset: expected %0d, got %0h",
                           hrt_pkg::HEADER_LIMIT_RST, rd));
    // limit 1 so that the second header line already overflows
    set_header_limit(7'd1);

    add_row(8'h00, 1, res_of(hrt_pkg::EV_DATA, hrt_pkg::TK_METHOD, 8'h00, 1'b1),
            NO_EV, NO_EV);
    add_row(hrt_pkg::CH_SP, 1, res_of(hrt_pkg::EV_END, hrt_pkg::TK_METHOD, 8'h00, 1'b1),
            NO_EV, NO_EV);
    add_row(hrt_pkg::CH_PCT, 0, NO_EV, NO_EV, NO_EV);
    add_row("0",             0, NO_EV, NO_EV, NO_EV);
    add_row("0", 1, res_of(hrt_pkg::EV_DATA, hrt_pkg::TK_URL, 8'h00, 1'b1),
            NO_EV, NO_EV);
    // broken escape: first '%' goes out as is, the second starts a new one
    add_row(hrt_pkg::CH_PCT,   PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_PCT,   PREDICT, NO_EV, NO_EV, NO_EV);
    add_row("4",               PREDICT, NO_EV, NO_EV, NO_EV);
    add_row("1",               PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_SP,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_COLON, PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_SP,    PREDICT, NO_EV, NO_EV, NO_EV);
    // CR not followed by LF is plain data
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(8'hFF, 2, res_of(hrt_pkg::EV_DATA, hrt_pkg::TK_VALUE, hrt_pkg::CH_CR, 1'b0),
            res_of(hrt_pkg::EV_DATA, hrt_pkg::TK_VALUE, 8'hFF, 1'b1), NO_EV);
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_COLON, PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_SP,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF, 2, res_of(hrt_pkg::EV_END, hrt_pkg::TK_VALUE, 8'h00, 1'b0),
            res_of(hrt_pkg::EV_OVF, hrt_pkg::TK_VALUE, 8'h00, 1'b1), NO_EV);
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF, 1, res_of(hrt_pkg::EV_DONE, hrt_pkg::TK_KEY, 8'h00, 1'b1),
            NO_EV, NO_EV);
    // empty request line, then a request line with no second space
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF, 1, res_of(hrt_pkg::EV_BAD, hrt_pkg::TK_METHOD, 8'h00, 1'b1),
            NO_EV, NO_EV);
    add_row(hrt_pkg::CH_SP,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_CR,    PREDICT, NO_EV, NO_EV, NO_EV);
    add_row(hrt_pkg::CH_LF, 1, res_of(hrt_pkg::EV_BAD, hrt_pkg::TK_URL, 8'h00, 1'b1),
            NO_EV, NO_EV);

    foreach (dir_rows[i]) send_byte(dir_rows[i]);
    drain();

    foreach (limit_plan[p]) begin
      set_header_limit(limit_plan[p]);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_request();
        foreach (req_bytes[j]) begin
          row = '0;
          row.b = req_bytes[j];
          send_byte(row);
        end
        phase_bytes += req_bytes.size();
      end
      drain();
    end

    $display("covered %0d request bytes and %0d result words under %0d header_limit settings",
             bytes_in, words_checked, settings_used);
    $display("token ends %0d, requests done %0d, malformed lines %0d, overflows %0d, errors %0d",
             event_tally[hrt_pkg::EV_END], event_tally[hrt_pkg::EV_DONE],
             event_tally[hrt_pkg::EV_BAD], event_tally[hrt_pkg::EV_OVF], mismatches);
    if (mismatches == 0) begin
      $display("http_request_tokenizer verification clean");
    end else begin
      $display("http_request_tokenizer verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("http_request_tokenizer verification failed");
    $finish;
  end

endmodule
